@@ rtl/cfge_pkg.sv @@
// Shared types and constants of the complex forward-difference gradient block.
package cfge_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIX_W   = 16;
    localparam int GRAD_W  = 18;
    localparam int COORD_W = 10;
    localparam int CFG_W   = 11;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

    typedef struct packed {
        logic signed [PIX_W-1:0] im;
        logic signed [PIX_W-1:0] re;
    } cpix_t;

endpackage

@@ rtl/cfge_line_store.sv @@
// Line store: one write and two registered reads per transaction.
module cfge_line_store #(
    parameter int DEPTH = cfge_pkg::DEF_MAX_WIDTH,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            aclk,
    input  logic            en,
    input  logic [AW-1:0]   addr_a,
    input  logic [AW-1:0]   addr_b,
    input  cfge_pkg::cpix_t wr_data,
    output cfge_pkg::cpix_t rd_data_a,
    output cfge_pkg::cpix_t rd_data_b
);
    import cfge_pkg::*;

    cpix_t mem [DEPTH];
    cpix_t rd_a_reg;
    cpix_t rd_b_reg;

    // read before write at addr_a
    always_ff @(posedge aclk) begin
        if (en) begin
            rd_a_reg     <= mem[addr_a];
            rd_b_reg     <= mem[addr_b];
            mem[addr_a]  <= wr_data;
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ rtl/cfge_grad.sv @@
// Complex gradient of one pixel from its own, right-hand and below samples; zero without a right neighbour.
module cfge_grad (
    input  cfge_pkg::cpix_t                    centre,
    input  cfge_pkg::cpix_t                    right,
    input  cfge_pkg::cpix_t                    below,
    input  logic                               right_ok,
    output logic signed [cfge_pkg::GRAD_W-1:0] grad_re,
    output logic signed [cfge_pkg::GRAD_W-1:0] grad_im
);
    import cfge_pkg::*;

    logic signed [GRAD_W-1:0] c_re, c_im, r_re, r_im, b_re, b_im;

    always_comb begin
        c_re = GRAD_W'(centre.re);
        c_im = GRAD_W'(centre.im);
        r_re = GRAD_W'(right.re);
        r_im = GRAD_W'(right.im);
        b_re = GRAD_W'(below.re);
        b_im = GRAD_W'(below.im);
        if (right_ok) begin
            grad_re = (c_re - r_re) - (c_im - b_im);
            grad_im = (c_im - r_im) + (c_re - b_re);
        end else begin
            grad_re = '0;
            grad_im = '0;
        end
    end

endmodule

@@ rtl/complex_forward_gradient_edge.sv @@
// Top level of the streaming complex forward-difference gradient block.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    s_pixel_re, s_pixel_im
//  m_       out        m_valid/m_ready    m_grad_re, m_grad_im, m_out_col, m_out_row,
//                                         m_last_of_run
//  cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
//  One pixel per cycle outside the last row while the output is not stalled; in the
//  last row of a frame taller than one row, each pixel gives two results through
//  the single output register. Result path: line store read, then output register.
//  Reset clears counters and valid flags; the line store is not cleared.
//  A stalled output holds its result; the input stage still accepts pixels until one needs it.
module complex_forward_gradient_edge #(
    parameter int MAX_WIDTH  = cfge_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cfge_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [cfge_pkg::PIX_W-1:0]    s_pixel_re,
    input  logic signed [cfge_pkg::PIX_W-1:0]    s_pixel_im,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [cfge_pkg::GRAD_W-1:0]   m_grad_re,
    output logic signed [cfge_pkg::GRAD_W-1:0]   m_grad_im,
    output logic [cfge_pkg::COORD_W-1:0]         m_out_col,
    output logic [cfge_pkg::COORD_W-1:0]         m_out_row,
    output logic                                 m_last_of_run,
    input  logic                                 cfg_wr_en,
    input  logic [cfge_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cfge_pkg::CFG_W-1:0]           cfg_wdata
);
    import cfge_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT);
    localparam int HHW = $clog2(MAX_HEIGHT + 1);

    logic [CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [CW-1:0]    col_count_reg, col_count_next;
    logic [HW-1:0]    row_count_reg, row_count_next;

    logic [WW-1:0]    w_sel, c_cur, c_plus;
    logic [HHW-1:0]   h_sel, r_cur, r_nxt;
    logic             right_ok, last_row, above;
    logic             accept;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_phase_reg, s1_phase_next;
    cpix_t            s1_pix_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [HW-1:0]    s1_row_reg;
    logic             s1_above_reg, s1_last_row_reg, s1_right_ok_reg;

    cpix_t            store_a, store_b, pix_in;
    logic signed [GRAD_W-1:0] grad_re, grad_im;

    logic             out_free, emit, done;
    logic             m_valid_reg, m_valid_next;
    logic signed [GRAD_W-1:0] m_grad_re_reg, m_grad_im_reg;
    logic [COORD_W-1:0] m_out_col_reg, m_out_row_reg;
    logic             m_last_reg;
    logic signed [GRAD_W-1:0] e_grad_re, e_grad_im;
    logic [COORD_W-1:0] e_col, e_row;
    logic             e_last;
    logic [31:0]      col_ext, row_ext;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // position of the current pixel and the next one
    always_comb begin
        if (frame_width_reg == '0) begin
            w_sel = WW'(1);
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_sel = WW'(MAX_WIDTH);
        end else begin
            w_sel = WW'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_sel = HHW'(1);
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            h_sel = HHW'(MAX_HEIGHT);
        end else begin
            h_sel = HHW'(frame_height_reg);
        end

        c_cur = WW'(col_count_reg);
        r_cur = HHW'(row_count_reg);
        if (c_cur >= w_sel) begin
            c_cur = '0;
            r_cur = r_cur + HHW'(1);
        end
        if (r_cur >= h_sel) begin
            r_cur = '0;
        end

        c_plus   = c_cur + WW'(1);
        right_ok = c_plus < w_sel;
        last_row = r_cur == (h_sel - HHW'(1));
        above    = r_cur != '0;

        r_nxt = r_cur;
        if (c_plus >= w_sel) begin
            r_nxt = r_cur + HHW'(1);
            if (r_nxt >= h_sel) begin
                r_nxt = '0;
            end
        end

        if (accept) begin
            col_count_next = right_ok ? CW'(c_plus) : '0;
            row_count_next = HW'(r_nxt);
        end else begin
            col_count_next = col_count_reg;
            row_count_next = row_count_reg;
        end
    end

    assign pix_in = '{im: s_pixel_im, re: s_pixel_re};

    cfge_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_store (
        .aclk      (aclk),
        .en        (accept),
        .addr_a    (CW'(c_cur)),
        .addr_b    (CW'(c_plus)),
        .wr_data   (pix_in),
        .rd_data_a (store_a),
        .rd_data_b (store_b)
    );

    cfge_grad u_grad (
        .centre   (store_a),
        .right    (store_b),
        .below    (s1_pix_reg),
        .right_ok (s1_right_ok_reg),
        .grad_re  (grad_re),
        .grad_im  (grad_im)
    );

    // hand none, one or two results of a pixel to the output register
    always_comb begin
        out_free      = !m_valid_reg || m_ready;
        emit          = 1'b0;
        done          = 1'b0;
        s1_phase_next = s1_phase_reg;
        col_ext       = 32'(s1_col_reg);
        row_ext       = 32'(s1_row_reg);
        e_grad_re     = '0;
        e_grad_im     = '0;
        e_col         = col_ext[COORD_W-1:0];
        e_row         = row_ext[COORD_W-1:0];
        e_last        = 1'b1;

        if (s1_valid_reg) begin
            if (s1_above_reg && !s1_phase_reg) begin
                row_ext   = 32'(s1_row_reg - HW'(1));
                e_row     = row_ext[COORD_W-1:0];
                e_grad_re = grad_re;
                e_grad_im = grad_im;
                e_last    = !s1_last_row_reg;
                if (out_free) begin
                    emit = 1'b1;
                    if (s1_last_row_reg) begin
                        s1_phase_next = 1'b1;
                    end else begin
                        done = 1'b1;
                    end
                end
            end else if (s1_last_row_reg) begin
                if (out_free) begin
                    emit = 1'b1;
                    done = 1'b1;
                end
            end else begin
                done = 1'b1;
            end
        end

        s_ready = !s1_valid_reg || done;
        accept  = s_valid && s_ready;

        if (accept) begin
            s1_valid_next = 1'b1;
            s1_phase_next = 1'b0;
        end else if (done) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        m_valid_next = out_free ? emit : m_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            s1_valid_reg  <= 1'b0;
            s1_phase_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
            s1_valid_reg  <= s1_valid_next;
            s1_phase_reg  <= s1_phase_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg      <= pix_in;
            s1_col_reg      <= CW'(c_cur);
            s1_row_reg      <= HW'(r_cur);
            s1_above_reg    <= above;
            s1_last_row_reg <= last_row;
            s1_right_ok_reg <= right_ok;
        end
        if (emit) begin
            m_grad_re_reg <= e_grad_re;
            m_grad_im_reg <= e_grad_im;
            m_out_col_reg <= e_col;
            m_out_row_reg <= e_row;
            m_last_reg    <= e_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_grad_re     = m_grad_re_reg;
    assign m_grad_im     = m_grad_im_reg;
    assign m_out_col     = m_out_col_reg;
    assign m_out_row     = m_out_row_reg;
    assign m_last_of_run = m_last_reg;

endmodule

@@ rtl/cfge_checker.sv @@
// Port-level checks of the gradient block and their attachment to the top level.
module cfge_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [cfge_pkg::GRAD_W-1:0] m_grad_re,
    input logic signed [cfge_pkg::GRAD_W-1:0] m_grad_im,
    input logic                               m_last_of_run
);
    import cfge_pkg::*;

    // no transaction offered straight after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result offered after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_grad_re) && $stable(m_grad_im))
        else $error("stalled result changed");

    // the zero of the last row follows its partner without a gap
    a_pair: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last_of_run |=> m_valid && m_last_of_run)
        else $error("second result of a run missing");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_grad_re != 18'h1FFFF && m_grad_re != 18'h20000 &&
                    m_grad_re != 18'h20001 && m_grad_im != 18'h1FFFF &&
                    m_grad_im != 18'h20000 && m_grad_im != 18'h20001)
        else $error("gradient out of range");

endmodule

bind complex_forward_gradient_edge cfge_checker u_cfge_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_grad_re     (m_grad_re),
    .m_grad_im     (m_grad_im),
    .m_last_of_run (m_last_of_run)
);

@@ tb/sv/gradient_check_pkg.sv @@
// Gradient predictor and expected-result ledger for the complex forward-gradient testbench.
package gradient_check_pkg;
    import cfge_pkg::*;

    typedef struct packed {
        logic signed [GRAD_W-1:0] re;
        logic signed [GRAD_W-1:0] im;
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic                     last;
    } grad_item_t;

    class gradient_ledger;
        cpix_t       prev_row [DEF_MAX_WIDTH];
        int unsigned col_pos;
        int unsigned row_pos;
        int unsigned width_set;
        int unsigned height_set;
        grad_item_t  due_gradients [$];
        int unsigned faults;

        function new();
            col_pos    = 0;
            row_pos    = 0;
            width_set  = FRAME_WIDTH_RST;
            height_set = FRAME_HEIGHT_RST;
            faults     = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
            case (idx)
                REG_FRAME_WIDTH: begin
                    width_set = value;
                end
                REG_FRAME_HEIGHT: begin
                    height_set = value;
                end
                default: begin
                end
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v, int unsigned top);
            if (v < 1) begin
                return 1;
            end
            if (v > top) begin
                return top;
            end
            return v;
        endfunction

        function void take_pixel(logic signed [PIX_W-1:0] re, logic signed [PIX_W-1:0] im);
            int unsigned w;
            int unsigned h;
            int          gx_re;
            int          gx_im;
            int          gy_re;
            int          gy_im;
            bit          last_row;
            cpix_t       here;
            cpix_t       right;
            grad_item_t  g;
            w = clamp_dim(width_set, DEF_MAX_WIDTH);
            h = clamp_dim(height_set, DEF_MAX_HEIGHT);
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h) begin
                row_pos = 0;
            end
            last_row = (row_pos == h - 1);
            if (row_pos >= 1) begin
                g = '0;
                if (col_pos + 1 < w) begin
                    here  = prev_row[col_pos];
                    right = prev_row[col_pos + 1];
                    gx_re = int'(here.re) - int'(right.re);
                    gx_im = int'(here.im) - int'(right.im);
                    gy_re = int'(here.re) - int'(re);
                    gy_im = int'(here.im) - int'(im);
                    g.re  = GRAD_W'(gx_re - gy_im);
                    g.im  = GRAD_W'(gx_im + gy_re);
                end
                g.col  = COORD_W'(col_pos);
                g.row  = COORD_W'(row_pos - 1);
                g.last = !last_row;
                due_gradients.push_back(g);
            end
            if (last_row) begin
                g      = '0;
                g.col  = COORD_W'(col_pos);
                g.row  = COORD_W'(row_pos);
                g.last = 1'b1;
                due_gradients.push_back(g);
            end
            prev_row[col_pos] = '{im: im, re: re};
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h) begin
                    row_pos = 0;
                end
            end
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
                faults++;
            end
        endfunction

        function void match_gradient(grad_item_t got);
            grad_item_t want;
            if (due_gradients.size() == 0) begin
                $display("%0t: unexpected gradient re %0d im %0d col %0d row %0d last %0d",
                         $time, got.re, got.im, got.col, got.row, got.last);
                faults++;
                return;
            end
            want = due_gradients.pop_front();
            check_field("grad_re", int'(want.re), int'(got.re));
            check_field("grad_im", int'(want.im), int'(got.im));
            check_field("out_col", int'(want.col), int'(got.col));
            check_field("out_row", int'(want.row), int'(got.row));
            check_field("last_of_run", int'(want.last), int'(got.last));
        endfunction

        function int pending();
            return due_gradients.size();
        endfunction
    endclass

endpackage

@@ tb/sv/tb.sv @@
// Top-level testbench of the complex forward-difference gradient block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfge_pkg::*;
    import gradient_check_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 400;
    localparam int PRESSURE_PHASE = 4;
    localparam int FILL_COLS     = 32;

    localparam logic signed [PIX_W-1:0] MAXV = 16'sh7FFF;
    localparam logic signed [PIX_W-1:0] MINV = 16'sh8000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [PIX_W-1:0]    s_pixel_re = '0;
    logic signed [PIX_W-1:0]    s_pixel_im = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [GRAD_W-1:0]   m_grad_re;
    logic signed [GRAD_W-1:0]   m_grad_im;
    logic [COORD_W-1:0]         m_out_col;
    logic [COORD_W-1:0]         m_out_row;
    logic                       m_last_of_run;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_wdata = '0;

    gradient_ledger ledger = new();
    int unsigned    gap_pct = 0;
    int unsigned    stall_pct = 0;
    bit             hold_req = 1'b0;

    logic signed [PIX_W-1:0] corner_re [9] = '{MAXV, MINV, MAXV, MAXV, MINV, MAXV,
                                              MINV, MAXV, 16'sh0000};
    logic signed [PIX_W-1:0] corner_im [9] = '{MINV, MAXV, MINV, MAXV, MINV, MAXV,
                                              MAXV, MINV, 16'shFFFF};

    complex_forward_gradient_edge dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel_re    (s_pixel_re),
        .s_pixel_im    (s_pixel_im),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_grad_re     (m_grad_re),
        .m_grad_im     (m_grad_im),
        .m_out_col     (m_out_col),
        .m_out_row     (m_out_row),
        .m_last_of_run (m_last_of_run),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ledger.match_gradient('{re: m_grad_re, im: m_grad_im, col: m_out_col,
                                    row: m_out_row, last: m_last_of_run});
        end
    end

    // hold off for a long stretch on request, else stall at random
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_pixel(input logic signed [PIX_W-1:0] re,
                              input logic signed [PIX_W-1:0] im);
        @(negedge aclk);
        while ($urandom_range(99) < gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_pixel_re <= re;
        s_pixel_im <= im;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        ledger.take_pixel(re, im);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (ledger.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_wdata <= w;
        @(negedge aclk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_wdata <= h;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        ledger.write_register(REG_FRAME_WIDTH, w);
        ledger.write_register(REG_FRAME_HEIGHT, h);
    endtask

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 10) begin
            return CFG_W'($urandom_range(1));
        end
        if (roll < 18) begin
            return CFG_W'($urandom_range(2047, 1024));
        end
        if (roll < 28) begin
            return CFG_W'($urandom_range(1023, 17));
        end
        return CFG_W'($urandom_range(12, 2));
    endfunction

    initial begin
        int unsigned      sent;
        int unsigned      phase;
        int unsigned      n;
        idle_mode_t       mode;
        logic [CFG_W-1:0] w_pick;
        logic [CFG_W-1:0] h_pick;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // extremes on a 3x3 frame
        write_frame(11'd3, 11'd3);
        foreach (corner_re[i]) begin
            send_pixel(corner_re[i], corner_im[i]);
        end
        drain();

        // zero registers act as a 1x1 frame
        write_frame(11'd0, 11'd0);
        send_pixel(MINV, MAXV);
        send_pixel(16'sh0001, 16'shFFFE);
        drain();

        // oversize width clamps to full width; fill the low columns of the line store
        write_frame(11'd2047, 11'd1);
        repeat (FILL_COLS) begin
            send_pixel(PIX_W'($urandom), PIX_W'($urandom));
        end
        drain();

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS) begin
            if (phase == PRESSURE_PHASE) begin
                write_frame(11'd8, 11'd4);
            end else begin
                // wide frames stay on a single row
                w_pick = pick_dim();
                h_pick = pick_dim();
                if (int'(w_pick) > FILL_COLS) begin
                    h_pick = CFG_W'($urandom_range(1));
                end
                write_frame(w_pick, h_pick);
            end
            mode = idle_mode_t'(phase % 4);
            case (mode)
                IDLE_NONE: begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                IDLE_SENDER: begin
                    gap_pct   = 47;
                    stall_pct = 0;
                end
                IDLE_RECEIVER: begin
                    gap_pct   = 0;
                    stall_pct = 47;
                end
                default: begin
                    gap_pct   = 17;
                    stall_pct = 17;
                end
            endcase
            n = $urandom_range(60, 25);
            if (phase == PRESSURE_PHASE) begin
                hold_req = 1'b1;
                n = 60;
            end
            repeat (n) begin
                send_pixel(PIX_W'($urandom), PIX_W'($urandom));
            end
            drain();
            sent += n;
            phase++;
        end

        if (ledger.faults == 0) begin
            $display("PASS complex_forward_gradient_edge");
        end else begin
            $display("FAIL complex_forward_gradient_edge");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("FAIL complex_forward_gradient_edge");
        $finish;
    end

endmodule
